// ===== src/pmsl_pkg.sv =====
`default_nettype none

package pmsl_pkg;

    localparam int COUNT_W  = 16;
    localparam int SPEED_W  = 17;
    localparam int TARGET_W = 16;
    localparam int GAIN_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int ERR_W    = 18;
    localparam int PROD_W   = 27;
    localparam int INTEG_W  = 12;
    localparam int DUTY_W   = 7;
    localparam int SCALED_W = DUTY_W + PERIOD_W;
    localparam int CMP_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int OUT_SHIFT = 5;

    // floor(x / 100) == (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2**23
    localparam int DIV_SHIFT = 30;
    localparam int DIV_MUL_W = 24;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd10737419;

    localparam logic signed [SPEED_W-1:0] SPEED_MID = 17'sd32767;
    localparam logic [INTEG_W-1:0]        INTEG_MAX = 12'd3200;
    localparam logic [DUTY_W-1:0]         DUTY_MAX  = 7'd100;

    localparam logic [TARGET_W-1:0] TARGET_RST = 16'd0;
    localparam logic [GAIN_W-1:0]   PGAIN_RST  = 8'd8;
    localparam logic [GAIN_W-1:0]   IGAIN_RST  = 8'd8;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1200;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PGAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ERR   = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_INT   = 7'b0001000,
        ST_DUTY  = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_RECIP = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic calc_err;
        logic calc_mul;
        logic calc_int;
        logic calc_duty;
        logic calc_scale;
        logic load_out;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/pmsl_ctrl.sv =====
`default_nettype none

module pmsl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pmsl_pkg::t_cmd     o_cmd
);

    pmsl_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pmsl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = pmsl_pkg::ST_ERR;
                end
            end
            pmsl_pkg::ST_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state        = pmsl_pkg::ST_MUL;
            end
            pmsl_pkg::ST_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state        = pmsl_pkg::ST_INT;
            end
            pmsl_pkg::ST_INT: begin
                o_cmd.calc_int = 1'b1;
                n_state        = pmsl_pkg::ST_DUTY;
            end
            pmsl_pkg::ST_DUTY: begin
                o_cmd.calc_duty = 1'b1;
                n_state         = pmsl_pkg::ST_SCALE;
            end
            pmsl_pkg::ST_SCALE: begin
                o_cmd.calc_scale = 1'b1;
                n_state          = pmsl_pkg::ST_RECIP;
            end
            pmsl_pkg::ST_RECIP: begin
                // hold here until the previous result beat has left
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pmsl_pkg::ST_IDLE;
                end
            end
            default: n_state = pmsl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmsl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == pmsl_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> r_state == pmsl_pkg::ST_ERR)
        else $error("accepted beat did not start the sequence");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmsl_pkg::ST_RECIP && r_out_valid && !i_out_ready)
        |=> r_state == pmsl_pkg::ST_RECIP)
        else $error("result overwrote an untaken beat");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_out_valid && r_state == pmsl_pkg::ST_IDLE))
        else $error("result load did not raise valid");

endmodule

`default_nettype wire

// ===== src/pmsl_dp.sv =====
`default_nettype none

module pmsl_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pmsl_pkg::t_cmd                    i_cmd,
    input  wire logic                              i_cfg_we,
    input  wire logic [pmsl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pmsl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [pmsl_pkg::COUNT_W-1:0]      i_encoder_count,
    output logic signed [pmsl_pkg::SPEED_W-1:0]    o_measured_speed,
    output logic [pmsl_pkg::DUTY_W-1:0]            o_duty_percent,
    output logic [pmsl_pkg::CMP_W-1:0]             o_compare_value
);

    localparam int PW = pmsl_pkg::PROD_W;
    localparam int QW = pmsl_pkg::SCALED_W + pmsl_pkg::DIV_MUL_W;

    // configuration registers
    logic [pmsl_pkg::TARGET_W-1:0] r_target;
    logic [pmsl_pkg::GAIN_W-1:0]   r_pgain;
    logic [pmsl_pkg::GAIN_W-1:0]   r_igain;
    logic [pmsl_pkg::PERIOD_W-1:0] r_period;

    logic [pmsl_pkg::INTEG_W-1:0]  r_integral;

    logic signed [pmsl_pkg::SPEED_W-1:0] r_speed;
    logic signed [pmsl_pkg::ERR_W-1:0]   r_err;
    logic signed [PW-1:0]                r_ip;
    logic signed [PW-1:0]                r_pp;
    logic [pmsl_pkg::DUTY_W-1:0]         r_duty;
    logic [pmsl_pkg::SCALED_W-1:0]       r_scaled;

    logic signed [pmsl_pkg::SPEED_W-1:0] w_rpm;
    logic signed [PW-1:0]                w_err_x;
    logic signed [PW-1:0]                w_isum;
    logic [pmsl_pkg::INTEG_W-1:0]        w_integ;
    logic signed [PW-1:0]                w_raw;
    logic [PW-1-pmsl_pkg::OUT_SHIFT:0]   w_shifted;
    logic [pmsl_pkg::DUTY_W-1:0]         w_duty;
    logic [QW-1:0]                       w_qprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= pmsl_pkg::TARGET_RST;
            r_pgain  <= pmsl_pkg::PGAIN_RST;
            r_igain  <= pmsl_pkg::IGAIN_RST;
            r_period <= pmsl_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmsl_pkg::REG_TARGET: r_target <= i_cfg_data[pmsl_pkg::TARGET_W-1:0];
                pmsl_pkg::REG_PGAIN:  r_pgain  <= i_cfg_data[pmsl_pkg::GAIN_W-1:0];
                pmsl_pkg::REG_IGAIN:  r_igain  <= i_cfg_data[pmsl_pkg::GAIN_W-1:0];
                pmsl_pkg::REG_PERIOD: r_period <= i_cfg_data[pmsl_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // halve toward zero: add one before the shift when negative
    assign w_rpm = (r_speed + $signed({{(pmsl_pkg::SPEED_W-1){1'b0}}, r_speed[pmsl_pkg::SPEED_W-1]}))
                   >>> 1;

    assign w_err_x = $signed({{(PW-pmsl_pkg::ERR_W){r_err[pmsl_pkg::ERR_W-1]}}, r_err});

    assign w_isum = r_ip + $signed({{(PW-pmsl_pkg::INTEG_W){1'b0}}, r_integral});

    always_comb begin
        if (w_isum[PW-1]) begin
            w_integ = '0;
        end else if (w_isum > $signed({{(PW-pmsl_pkg::INTEG_W){1'b0}}, pmsl_pkg::INTEG_MAX})) begin
            w_integ = pmsl_pkg::INTEG_MAX;
        end else begin
            w_integ = w_isum[pmsl_pkg::INTEG_W-1:0];
        end
    end

    // r_integral already holds the updated value in this step
    assign w_raw     = r_pp + $signed({{(PW-pmsl_pkg::INTEG_W){1'b0}}, r_integral});
    assign w_shifted = w_raw[PW-1:pmsl_pkg::OUT_SHIFT];

    always_comb begin
        if (w_raw[PW-1]) begin
            w_duty = '0;
        end else if (w_shifted > {{(PW-pmsl_pkg::OUT_SHIFT-pmsl_pkg::DUTY_W){1'b0}},
                                  pmsl_pkg::DUTY_MAX}) begin
            w_duty = pmsl_pkg::DUTY_MAX;
        end else begin
            w_duty = w_shifted[pmsl_pkg::DUTY_W-1:0];
        end
    end

    assign w_qprod = {{pmsl_pkg::DIV_MUL_W{1'b0}}, r_scaled}
                   * {{pmsl_pkg::SCALED_W{1'b0}}, pmsl_pkg::DIV_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
        end else if (i_cmd.calc_int) begin
            r_integral <= w_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_speed <= $signed({1'b0, i_encoder_count}) - pmsl_pkg::SPEED_MID;
        end
        if (i_cmd.calc_err) begin
            r_err <= $signed({{(pmsl_pkg::ERR_W-pmsl_pkg::TARGET_W){r_target[pmsl_pkg::TARGET_W-1]}},
                              r_target})
                   - $signed({w_rpm[pmsl_pkg::SPEED_W-1], w_rpm});
        end
        if (i_cmd.calc_mul) begin
            r_ip <= $signed({{(PW-pmsl_pkg::GAIN_W){1'b0}}, r_igain}) * w_err_x;
            r_pp <= $signed({{(PW-pmsl_pkg::GAIN_W){1'b0}}, r_pgain}) * w_err_x;
        end
        if (i_cmd.calc_duty) begin
            r_duty <= w_duty;
        end
        if (i_cmd.calc_scale) begin
            r_scaled <= {{pmsl_pkg::PERIOD_W{1'b0}}, r_duty}
                      * {{pmsl_pkg::DUTY_W{1'b0}}, r_period};
        end
        if (i_cmd.load_out) begin
            o_measured_speed <= r_speed;
            o_duty_percent   <= r_duty;
            o_compare_value  <= w_qprod[pmsl_pkg::DIV_SHIFT +: pmsl_pkg::CMP_W];
        end
    end

    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integral <= pmsl_pkg::INTEG_MAX)
        else $error("integral left its clamp range");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> o_duty_percent <= pmsl_pkg::DUTY_MAX)
        else $error("duty above limit");

    a_cmp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> o_compare_value <= $past(r_period))
        else $error("compare value above period");

endmodule

`default_nettype wire

// ===== src/pi_motor_speed_loop.sv =====
// An encoder beat is accepted only in idle; it then runs through the fixed step sequence of
// one shared datapath (error, products, integral, duty, period scaling, reciprocal divide),
// and the result is loaded at the final step, so a new beat waits until the last one is done.
// A waiting result stalls only the final step.
// Reset (i_rst_n low, synchronous): sequencer idle, no result valid, integral zero,
// registers back to defaults (target 0, gains 8, period 1200).
`default_nettype none

module pi_motor_speed_loop (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [pmsl_pkg::COUNT_W-1:0]        i_encoder_count,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [pmsl_pkg::SPEED_W-1:0]      o_measured_speed,
    output logic [pmsl_pkg::DUTY_W-1:0]              o_duty_percent,
    output logic [pmsl_pkg::CMP_W-1:0]               o_compare_value,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pmsl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pmsl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pmsl_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    pmsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    pmsl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_encoder_count  (i_encoder_count),
        .o_measured_speed (o_measured_speed),
        .o_duty_percent   (o_duty_percent),
        .o_compare_value  (o_compare_value)
    );

endmodule

`default_nettype wire

// ===== tb/pi_motor_speed_loop_checker.sv =====
`timescale 1ns / 100ps

module pi_motor_speed_loop_checker
    import pmsl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [COUNT_W-1:0]          i_encoder_count,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [SPEED_W-1:0]   i_measured_speed,
    input  logic [DUTY_W-1:0]           i_duty_percent,
    input  logic [CMP_W-1:0]            i_compare_value,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    typedef struct {
        logic signed [SPEED_W-1:0] speed;
        logic [DUTY_W-1:0]         duty;
        logic [CMP_W-1:0]          cmp;
    } drive_t;

    // shadow copy of the loop registers and integrator
    int set_speed;
    int kp;
    int ki;
    int period;
    int integ_acc;

    drive_t drive_q[$];

    function automatic drive_t predict_drive(input logic [COUNT_W-1:0] count);
        drive_t d;
        int speed;
        int rpm;
        int err;
        int acc;
        int raw;
        int duty;
        speed = int'(count) - int'(SPEED_MID);
        rpm   = speed / 2;  // truncates toward zero
        err   = set_speed - rpm;
        acc   = integ_acc + ki * err;
        if (acc < 0)
            acc = 0;
        else if (acc > int'(INTEG_MAX))
            acc = int'(INTEG_MAX);
        integ_acc = acc;
        raw = kp * err + acc;
        if (raw < 0)
            duty = 0;
        else begin
            duty = raw >>> OUT_SHIFT;
            if (duty > int'(DUTY_MAX))
                duty = int'(DUTY_MAX);
        end
        d.speed = speed[SPEED_W-1:0];
        d.duty  = duty[DUTY_W-1:0];
        d.cmp   = CMP_W'((duty * period) / int'(DUTY_MAX));
        return d;
    endfunction

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            o_fail_count = o_fail_count + 1;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, fname, want, got);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        drive_t want;
        if (!i_rst_n) begin
            set_speed = int'(signed'(TARGET_RST));
            kp        = int'(PGAIN_RST);
            ki        = int'(IGAIN_RST);
            period    = int'(PERIOD_RST);
            integ_acc = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TARGET: set_speed = int'($signed(i_cfg_data));
                    REG_PGAIN:  kp        = int'(i_cfg_data[GAIN_W-1:0]);
                    REG_IGAIN:  ki        = int'(i_cfg_data[GAIN_W-1:0]);
                    REG_PERIOD: period    = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                drive_q.push_back(predict_drive(i_encoder_count));
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t ns: result beat with nothing expected, %s %0d %0d %0d",
                             $time, "speed duty cmp", i_measured_speed, i_duty_percent,
                             i_compare_value);
                end else begin
                    want = drive_q.pop_front();
                    check_field("measured_speed", int'(want.speed), int'(i_measured_speed));
                    check_field("duty_percent", int'(want.duty), int'(i_duty_percent));
                    check_field("compare_value", int'(want.cmp), int'(i_compare_value));
                    o_checked = o_checked + 1;
                end
            end
        end
        o_pending <= drive_q.size();
    end

endmodule

// ===== tb/pi_motor_speed_loop_tb.sv =====
`timescale 1ns / 100ps

module pi_motor_speed_loop_tb;
    import pmsl_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RAND_PHASES   = 16;
    localparam int PHASE_ITEMS   = 100;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [COUNT_W-1:0]         i_encoder_count = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SPEED_W-1:0]  o_measured_speed;
    logic [DUTY_W-1:0]          o_duty_percent;
    logic [CMP_W-1:0]           o_compare_value;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;
    int cur_target = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pi_motor_speed_loop u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_encoder_count  (i_encoder_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_measured_speed (o_measured_speed),
        .o_duty_percent   (o_duty_percent),
        .o_compare_value  (o_compare_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    pi_motor_speed_loop_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_encoder_count  (i_encoder_count),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_measured_speed (o_measured_speed),
        .i_duty_percent   (o_duty_percent),
        .i_compare_value  (o_compare_value),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // result-side backpressure: random stall bursts of i_out_ready low
    always @(negedge i_clk) begin
        if (no_idle) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left = $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: watchdog, no beat for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // caller lowers i_cfg_valid after the last write of a batch
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_writes++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic load_loop(input int tgt, input logic [CFG_DATA_W-1:0] pg,
                             input logic [CFG_DATA_W-1:0] ig, input int per);
        drain();
        cfg_write(REG_TARGET, CFG_DATA_W'(tgt));
        cfg_write(REG_PGAIN, pg);
        cfg_write(REG_IGAIN, ig);
        cfg_write(REG_PERIOD, CFG_DATA_W'(per));
        i_cfg_valid <= 1'b0;
        cur_target = tgt;
    endtask

    task automatic send_count(input int count);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_encoder_count <= COUNT_W'(count);
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    function automatic int pick_count(input int tgt);
        int sel;
        int c;
        sel = $urandom_range(0, 99);
        // mostly near the operating point so the loop sees small errors
        if (sel < 40)
            c = 32767 + 2 * tgt + int'($urandom_range(0, 400)) - 200;
        else if (sel < 60)
            c = 32767 + 2 * tgt + int'($urandom_range(0, 8000)) - 4000;
        else if (sel < 85)
            c = $urandom_range(0, 65535);
        else begin
            case ($urandom_range(0, 4))
                0: c = 0;
                1: c = 65535;
                2: c = 32767;
                3: c = 32768;
                default: c = 32766;
            endcase
        end
        if (c < 0)
            c = 0;
        else if (c > 65535)
            c = 65535;
        return c;
    endfunction

    function automatic int pick_target();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return int'($urandom_range(0, 600)) - 300;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 4))
            0: g = 8'd0;
            1: g = 8'd255;
            2: g = GAIN_W'($urandom_range(1, 16));
            default: g = GAIN_W'($urandom_range(0, 255));
        endcase
        // upper data bits are don't-care for the gain registers
        return {CFG_DATA_W'($urandom_range(0, 255)) << GAIN_W} | CFG_DATA_W'(g);
    endfunction

    function automatic int pick_period();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 65535;
            2: return 1200;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: midpoint, rails, odd counts around the midpoint
        send_count(32767);
        send_count(0);
        send_count(65535);
        send_count(32768);
        send_count(32766);
        send_count(1);
        send_count(65534);

        // integrator winds up to its ceiling, zero period gives zero compare
        load_loop(32767, 16'h0000, 16'h00FF, 0);
        send_count(0);
        send_count(0);
        send_count(32767);

        // large negative error: raw output negative so duty clamps to zero, integrator pinned at zero
        load_loop(-32768, 16'hFFFF, 16'hFFFF, 65535);
        send_count(65535);
        send_count(65535);
        send_count(32767);

        // proportional only: duties at the limit, in between, at zero and clamped above the limit
        load_loop(0, 16'h0001, 16'h0000, 65535);
        send_count(32767 - 2 * 3200);
        send_count(32767 - 2 * 320);
        send_count(32767 - 2 * 3);
        send_count(32767 - 2 * 3300);

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            load_loop(pick_target(), pick_gain(), pick_gain(), pick_period());
            if (phase == RAND_PHASES - 1)
                no_idle = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_count(pick_count(cur_target));
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d encoder beats and %0d register writes over %0d loop settings;",
                 items_sent, cfg_writes, RAND_PHASES + 4);
        $display("%0d results compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
